@@ hw/rtl/assert_macros.svh @@
// Assertion helpers: every check is clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge of clk.
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold on the same edge.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nmdf_pkg.sv @@
package nmdf_pkg;

  localparam logic [6:0] FIRST_YEAR = 7'd18;
  localparam logic [6:0] LAST_YEAR  = 7'd99;

  localparam logic [2:0] KIND_ANY   = 3'd0;
  localparam logic [2:0] KIND_DAY   = 3'd1;
  localparam logic [2:0] KIND_WDAY  = 3'd2;
  localparam logic [2:0] KIND_MDAY  = 3'd3;
  localparam logic [2:0] KIND_FULL  = 3'd4;

  typedef struct packed {
    logic [6:0] ref_year;
    logic [3:0] ref_month;
    logic [4:0] ref_day;
    logic [2:0] match_kind;
    logic [4:0] want_day;
    logic [2:0] want_weekday;
    logic [3:0] want_month;
    logic [6:0] want_year;
  } nmdf_in_t;

  typedef struct packed {
    logic        found;
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  out_weekday;
    logic [14:0] day_serial;
  } nmdf_out_t;

  function automatic logic [4:0] days_in_month(input logic [6:0] year,
                                               input logic [3:0] month);
    logic [4:0] n;
    unique case (month)
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2:                    n = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // Valid for v < 42.
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd28) r = r - 6'd28;
    if (r >= 6'd14) r = r - 6'd14;
    if (r >= 6'd7)  r = r - 6'd7;
    return r[2:0];
  endfunction

endpackage

@@ hw/rtl/next_matching_date_finder.sv @@
// Adds years from FIRST_YEAR, then months and the day offset, then walks day by
//   day to a match or past LAST_YEAR; an invalid reference skips to S_DONE.
// One shared serial adder: one year, one month or one day per cycle.
// One item at a time; the next input beat is taken once the result
//   has moved into the output register.
// Reset: rst (synchronous, active high) returns to idle and drops out_valid.
`include "assert_macros.svh"

module next_matching_date_finder import nmdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  nmdf_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output nmdf_out_t out_item
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_YEARS  = 3'd1;
  localparam logic [2:0] S_MONTHS = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]  st;
  nmdf_in_t    req;
  logic [6:0]  y, iy;
  logic [3:0]  m, im;
  logic [4:0]  d;
  logic [14:0] serial;
  logic [2:0]  wd;
  logic        found;

  logic [8:0]  addend;
  logic [4:0]  wd_add;
  logic [14:0] serial_sum;
  logic [2:0]  wd_sum;
  logic [4:0]  dim_cur, dim_im, dim_in;
  logic [6:0]  ny;
  logic [3:0]  nm;
  logic [4:0]  nd;
  logic        past_end, hit, in_bad, load_out;

  assign in_stall = (st != S_IDLE);
  assign load_out = (st == S_DONE) && (!out_valid || !out_stall);

  assign dim_cur = days_in_month(y, m);
  assign dim_im  = days_in_month(y, im);
  assign dim_in  = days_in_month(in_item.ref_year, in_item.ref_month);

  assign in_bad = (in_item.ref_year < FIRST_YEAR) || (in_item.ref_year > LAST_YEAR) ||
                  (in_item.ref_month < 4'd1) || (in_item.ref_month > 4'd12) ||
                  (in_item.ref_day < 5'd1) || (in_item.ref_day > dim_in);

  // shared serial / weekday adder
  always_comb begin
    addend = 9'd0;
    wd_add = 5'd0;
    unique case (st)
      S_YEARS: begin
        addend = (iy[1:0] == 2'd0) ? 9'd366 : 9'd365;
        wd_add = (iy[1:0] == 2'd0) ? 5'd2 : 5'd1;
      end
      S_MONTHS: begin
        if (im < m) begin
          addend = {4'd0, dim_im};
          wd_add = dim_im;
        end else begin
          addend = {4'd0, d - 5'd1};
          wd_add = d - 5'd1;
        end
      end
      S_WALK: begin
        addend = 9'd1;
        wd_add = 5'd1;
      end
      default: begin
        addend = 9'd0;
        wd_add = 5'd0;
      end
    endcase
  end

  assign serial_sum = serial + {6'd0, addend};
  assign wd_sum     = mod7({3'd0, wd} + {1'b0, wd_add});

  // next day
  always_comb begin
    nd = d + 5'd1;
    nm = m;
    ny = y;
    past_end = 1'b0;
    if (d >= dim_cur) begin
      nd = 5'd1;
      if (m < 4'd12) begin
        nm = m + 4'd1;
      end else begin
        nm = 4'd1;
        ny = y + 7'd1;
        past_end = (ny > LAST_YEAR);
      end
    end
  end

  always_comb begin
    unique case (req.match_kind)
      KIND_ANY:  hit = 1'b1;
      KIND_DAY:  hit = (nd == req.want_day);
      KIND_WDAY: hit = (wd_sum == req.want_weekday);
      KIND_MDAY: hit = (nd == req.want_day) && (nm == req.want_month);
      KIND_FULL: hit = (nd == req.want_day) && (nm == req.want_month) &&
                       (ny == req.want_year);
      default:   hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            st <= in_bad ? S_DONE : S_YEARS;
          end
        end
        S_YEARS:  if (iy >= y) st <= S_MONTHS;
        S_MONTHS: if (im >= m) st <= S_WALK;
        S_WALK:   if (past_end || hit) st <= S_DONE;
        S_DONE:   if (load_out) st <= S_IDLE;
        default:  st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        req    <= in_item;
        y      <= in_item.ref_year;
        m      <= in_item.ref_month;
        d      <= in_item.ref_day;
        iy     <= FIRST_YEAR;
        im     <= 4'd1;
        serial <= 15'd0;
        wd     <= 3'd0;
        found  <= 1'b0;
      end
      S_YEARS: begin
        if (iy < y) begin
          serial <= serial_sum;
          wd     <= wd_sum;
          iy     <= iy + 7'd1;
        end
      end
      S_MONTHS: begin
        serial <= serial_sum;
        wd     <= wd_sum;
        if (im < m) im <= im + 4'd1;
      end
      S_WALK: begin
        if (!past_end) begin
          y      <= ny;
          m      <= nm;
          d      <= nd;
          serial <= serial_sum;
          wd     <= wd_sum;
          found  <= hit;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_item.found       <= found;
      out_item.out_year    <= found ? y : 7'd0;
      out_item.out_month   <= found ? m : 4'd0;
      out_item.out_day     <= found ? d : 5'd0;
      out_item.out_weekday <= found ? wd : 3'd0;
      out_item.day_serial  <= found ? serial : 15'd0;
    end
  end

  `CHK_IMPL(a_walk_date_ok, st == S_WALK,
            d >= 5'd1 && d <= dim_cur && y <= LAST_YEAR && wd < 3'd7,
            "walk date out of range")
  `CHK_IMPL(a_miss_zero, out_valid && !out_item.found,
            out_item.day_serial == 15'd0 && out_item.out_day == 5'd0,
            "miss result carries data")
  `CHK_CLK(a_hit_wday, !(out_valid && out_item.found) ||
           (out_item.out_weekday < 3'd7 && out_item.out_day != 5'd0),
           "hit result weekday or day invalid")

endmodule
